@@ sv/lts_pkg.sv @@
// Shared constants, codes and structs for the LRU tag store.
// No dependencies; every other file in this folder imports this package.
package lts_pkg;

  localparam int ENTRIES   = 128;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int TICK_BITS = 32;
  localparam int KEY_W     = 64;
  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 7;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd3;

  // Control from the sequencer to the search unit, one slot per cycle.
  typedef struct packed {
    logic             clear;
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             vbit;
  } scan_ctl_t;

  // Accumulated result of a full pass over the slots.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic [IDX_W-1:0] vict_idx;
    logic             vict_valid;
    logic [KEY_W-1:0] vict_key;
  } scan_res_t;

endpackage

@@ sv/lts_search.sv @@
// Search unit: one slot per cycle while ctl.en is set, tracks the first matching valid key and
// the first slot with the smallest age (invalid slots count as age zero).
// Depends on lts_pkg.
module lts_search (
  input  logic                           clk,
  input  logic                           rst,
  input  lts_pkg::scan_ctl_t             ctl,
  input  logic [lts_pkg::KEY_W-1:0]      key,
  input  logic [lts_pkg::KEY_W-1:0]      rd_key,
  input  logic [lts_pkg::TICK_BITS-1:0]  rd_age,
  output lts_pkg::scan_res_t             res
);
  import lts_pkg::*;

  logic                 has_best;
  logic [TICK_BITS-1:0] best_age;
  logic [TICK_BITS-1:0] cur_age;
  logic                 take;

  assign cur_age = ctl.vbit ? rd_age : '0;
  assign take    = !has_best || (cur_age < best_age);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      has_best  <= 1'b0;
      res.found <= 1'b0;
    end else if (ctl.en) begin
      if (!res.found && ctl.vbit && rd_key == key) begin
        res.found     <= 1'b1;
        res.found_idx <= ctl.idx;
      end
      if (take) begin
        has_best       <= 1'b1;
        best_age       <= cur_age;
        res.vict_idx   <= ctl.idx;
        res.vict_valid <= ctl.vbit;
        res.vict_key   <= rd_key;
      end
    end
  end

endmodule

@@ sv/lru_tag_store_with_fill_core.sv @@
// Fully associative tag store with LRU replacement: a tick advance goes from
// acceptance straight to the output state; lookup, insert and preload scan the
// slots one per cycle through the single read port of the key and age memories,
// then go through drain and write; every result holds in the output state on out_stall.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module lru_tag_store_with_fill_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lts_pkg::KIND_W-1:0]    kind,
  input  logic [lts_pkg::KEY_W-1:0]     key,
  input  logic                          fill_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [lts_pkg::SLOT_W-1:0]    slot,
  output logic                          installed,
  output logic                          evicted_valid,
  output logic [lts_pkg::KEY_W-1:0]     evicted_key
);
  import lts_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]           state;
  logic [IDX_W-1:0]     cnt;
  logic [KIND_W-1:0]    kind_r;
  logic [KEY_W-1:0]     key_r;
  logic                 fill_r;
  logic [TICK_BITS-1:0] now_tick;
  logic [ENTRIES-1:0]   slot_valid;
  logic [IDX_W-1:0]     out_idx;

  logic [KEY_W-1:0]     key_mem [ENTRIES];
  logic [TICK_BITS-1:0] age_mem [ENTRIES];
  logic [KEY_W-1:0]     rd_key;
  logic [TICK_BITS-1:0] rd_age;
  logic                 rd_vbit;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_idx;

  scan_ctl_t            ctl;
  scan_res_t            res;

  logic                 do_hit;
  logic                 do_fill;
  logic [TICK_BITS-1:0] new_age;
  logic [IDX_W-1:0]     wr_idx;
  logic                 age_we;
  logic                 key_we;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  assign ctl.clear = (state == ST_IDLE);
  assign ctl.en    = rd_en;
  assign ctl.idx   = rd_idx;
  assign ctl.vbit  = rd_vbit;

  lts_search u_search (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .key    (key_r),
    .rd_key (rd_key),
    .rd_age (rd_age),
    .res    (res)
  );

  // A lookup miss only fills when the backing store can supply the item.
  assign do_hit  = res.found;
  assign do_fill = !res.found && (kind_r != KIND_LOOKUP || fill_r);
  assign new_age = (kind_r == KIND_PRELOAD) ? TICK_BITS'(1) : now_tick;
  assign wr_idx  = do_hit ? res.found_idx : res.vict_idx;
  assign age_we  = (state == ST_WRITE) && (do_hit || do_fill);
  assign key_we  = (state == ST_WRITE) && do_fill;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_r;
    end
    if (age_we) begin
      age_mem[wr_idx] <= new_age;
    end
    rd_key  <= key_mem[cnt];
    rd_age  <= age_mem[cnt];
    rd_vbit <= slot_valid[cnt];
    rd_idx  <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_en      <= 1'b0;
      cnt        <= '0;
      now_tick   <= '0;
      slot_valid <= '0;
    end else begin
      rd_en <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            kind_r <= kind;
            key_r  <= key;
            fill_r <= fill_ready;
            if (kind == KIND_TICK) begin
              if (now_tick != '1) begin
                now_tick <= now_tick + 1'b1;
              end
              hit           <= 1'b0;
              out_idx       <= '0;
              installed     <= 1'b0;
              evicted_valid <= 1'b0;
              evicted_key   <= '0;
              state         <= ST_OUT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(ENTRIES - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          hit           <= do_hit;
          installed     <= do_fill || (do_hit && kind_r != KIND_LOOKUP);
          out_idx       <= (do_hit || do_fill) ? wr_idx : '0;
          evicted_valid <= do_fill && res.vict_valid;
          evicted_key   <= (do_fill && res.vict_valid) ? res.vict_key : '0;
          if (do_fill) begin
            slot_valid[res.vict_idx] <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign slot = SLOT_W'(out_idx);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("store accepted a transaction but did not go busy");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_key == '0)
    else $error("evicted key nonzero without an eviction");

  a_installed_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && installed |-> slot_valid[out_idx])
    else $error("installed slot is not marked valid");

endmodule
